/* rtl/core/fcf_pkg.sv */
// Shared types and register index codes for the feedback comb filter.
package fcf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int PRODUCT_W  = SAMPLE_W + GAIN_W;
    localparam int LENGTH_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [GAIN_W-1:0]    gain_t;
    typedef logic signed [PRODUCT_W-1:0] product_t;
    typedef logic [LENGTH_W-1:0]         length_t;
    typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]       cfg_data_t;

    localparam cfg_idx_t CFG_DELAY_LENGTH = 2'd0;
    localparam cfg_idx_t CFG_INPUT_GAIN   = 2'd1;
    localparam cfg_idx_t CFG_LOOP_GAIN    = 2'd2;

    localparam length_t RESET_DELAY_LENGTH = 13'd4096;
    localparam gain_t   RESET_INPUT_GAIN   = 16'sd16384;
    localparam gain_t   RESET_LOOP_GAIN    = 16'sd0;

endpackage

/* rtl/core/fcf_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/feedback_comb_filter.sv */
// Feedback comb filter: y = (input_gain*x + loop_gain*d) / 2^14, saturated, with a delay line held in RAM.
// Pipeline: an accepted sample passes the s1 and s2 registers and is then registered onto sample_out.
// Throughput: one sample per cycle while sample_out is not stalled, for an active delay length of
// two or more; with a length of one, a new sample waits until the last one has left the s1 stage,
// since each result must leave the product stage and be written from the sum stage before the next read.
// Reset: registers take their reset values; a fill mark makes unwritten entries read as zero.
module feedback_comb_filter #(
    parameter int MAX_DELAY = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  fcf_pkg::cfg_idx_t cfg_addr,
    input  fcf_pkg::cfg_data_t cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  fcf_pkg::sample_t  sample_in,
    output logic              out_valid,
    input  logic              out_ready,
    output fcf_pkg::sample_t  sample_out
);

    import fcf_pkg::*;

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW = AW + 1;
    localparam int CW = (LW > LENGTH_W) ? LW : LENGTH_W;

    // Configuration registers.
    length_t delay_length_reg;
    gain_t   input_gain_reg;
    gain_t   loop_gain_reg;

    // Pointer and fill mark (entries at or above the mark were never written).
    logic [AW-1:0] ptr_reg;
    logic [LW-1:0] fill_reg;

    // Pipeline registers.
    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    sample_t       s1_x_reg;
    logic          s1_zero_reg;
    logic          s2_valid_reg;
    logic [AW-1:0] s2_addr_reg;
    product_t      s2_px_reg;
    product_t      s2_pd_reg;
    logic          out_valid_reg;
    sample_t       out_data_reg;

    // Last write to the RAM, used to forward data that a read missed.
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    sample_t       wb_data_reg;

    logic [CW-1:0]         len_ext;
    logic [LW-1:0]         eff_len;
    logic [LW-1:0]         ptr_inc;
    logic [AW-1:0]         ptr_next;
    logic                  entry_zero;
    logic                  en_out;
    logic                  en_s2;
    logic                  en_s1;
    logic                  hazard;
    logic                  accept;
    logic                  ram_we;
    logic [SAMPLE_W-1:0]   ram_rdata;
    sample_t               delayed;
    product_t              prod_x;
    product_t              prod_d;
    logic signed [PRODUCT_W:0] acc;
    logic signed [PRODUCT_W:0] acc_biased;
    logic [PRODUCT_W-14:0] quot;
    sample_t               result;

    // Active delay length: zero acts as one, anything above the RAM depth as the depth.
    always_comb
    begin
        len_ext = CW'(delay_length_reg);
        if (delay_length_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (len_ext > CW'(MAX_DELAY))
        begin
            eff_len = LW'(MAX_DELAY);
        end
        else
        begin
            eff_len = LW'(len_ext);
        end
    end

    assign ptr_inc    = {1'b0, ptr_reg} + LW'(1);
    assign ptr_next   = (ptr_inc >= eff_len) ? '0 : ptr_inc[AW-1:0];
    assign entry_zero = ({1'b0, ptr_reg} >= fill_reg);

    assign en_out = !out_valid_reg || out_ready;
    assign en_s2  = !s2_valid_reg || en_out;
    assign en_s1  = !s1_valid_reg || en_s2;

    // A new read may not target an entry whose result is still being computed.
    assign hazard = (s1_valid_reg && (s1_addr_reg == ptr_reg))
                 || (s2_valid_reg && !en_out && (s2_addr_reg == ptr_reg));

    assign in_ready = en_s1 && !hazard;
    assign accept   = in_valid && in_ready;
    assign ram_we   = s2_valid_reg && en_out;

    fcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_addr_reg),
        .wdata (result),
        .re    (en_s1),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // The write that lands on the same edge as this read is not seen by the RAM output.
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
        begin
            delayed = wb_data_reg;
        end
        else if (s1_zero_reg)
        begin
            delayed = '0;
        end
        else
        begin
            delayed = sample_t'(ram_rdata);
        end
    end

    assign prod_x = input_gain_reg * s1_x_reg;
    assign prod_d = loop_gain_reg * delayed;

    // Divide by 2^14 rounding toward zero, then saturate to 16 bits.
    always_comb
    begin
        acc        = {s2_px_reg[PRODUCT_W-1], s2_px_reg} + {s2_pd_reg[PRODUCT_W-1], s2_pd_reg};
        acc_biased = acc + (acc[PRODUCT_W] ? (PRODUCT_W+1)'(16383) : '0);
        quot       = acc_biased[PRODUCT_W:14];
        if (quot[PRODUCT_W-14:SAMPLE_W-1] == '0 || quot[PRODUCT_W-14:SAMPLE_W-1] == '1)
        begin
            result = sample_t'(quot[SAMPLE_W-1:0]);
        end
        else if (quot[PRODUCT_W-14])
        begin
            result = 16'sh8000;
        end
        else
        begin
            result = 16'sh7fff;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= RESET_DELAY_LENGTH;
            input_gain_reg   <= RESET_INPUT_GAIN;
            loop_gain_reg    <= RESET_LOOP_GAIN;
            ptr_reg          <= '0;
            fill_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            wb_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_DELAY_LENGTH:
                    begin
                        delay_length_reg <= cfg_data[LENGTH_W-1:0];
                    end
                    CFG_INPUT_GAIN:
                    begin
                        input_gain_reg <= gain_t'(cfg_data);
                    end
                    CFG_LOOP_GAIN:
                    begin
                        loop_gain_reg <= gain_t'(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
            end
            // A length write restarts the pointer at the head of the line.
            if (cfg_we && (cfg_addr == CFG_DELAY_LENGTH))
            begin
                ptr_reg <= '0;
            end
            else if (accept)
            begin
                ptr_reg <= ptr_next;
            end
            if (accept && entry_zero)
            begin
                fill_reg <= ptr_inc;
            end
            if (en_s1)
            begin
                s1_valid_reg <= accept;
            end
            if (en_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (ram_we)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            s1_addr_reg <= ptr_reg;
            s1_x_reg    <= sample_in;
            s1_zero_reg <= entry_zero;
        end
        if (en_s2)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_px_reg   <= prod_x;
            s2_pd_reg   <= prod_d;
        end
        if (ram_we)
        begin
            out_data_reg <= result;
            wb_addr_reg  <= s2_addr_reg;
            wb_data_reg  <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

`ifndef SYNTH
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ptr_reg} < eff_len))
        else $error("write pointer at or beyond the active delay length");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= LW'(MAX_DELAY)))
        else $error("fill mark beyond the delay line depth");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg && (s1_addr_reg == s2_addr_reg)))
        else $error("two in-flight samples target the same delay entry");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && entry_zero && !cfg_we) |=> (fill_reg == $past(fill_reg) + LW'(1)))
        else $error("fill mark did not advance over a first write");
`endif

endmodule
